/* src/crf_pkg.sv */
package crf_pkg;

  localparam int MAX_SIDE_DEF  = 256;
  localparam int FRAC_BITS_DEF = 8;

  // Fixed field widths of the item and the configuration registers.
  localparam int FIELD_W  = 24;
  localparam int AREA_W   = 9;
  localparam int AREA_MAX = 511;
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_DRAW  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AREA_WIDTH  = 2'd0,
    CFG_AREA_HEIGHT = 2'd1,
    CFG_BACKGROUND  = 2'd2
  } cfg_idx_t;

  localparam logic [AREA_W-1:0] AREA_RESET = 9'd256;
  localparam logic [BYTE_W-1:0] BG_RESET   = 8'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_READ,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;      // latch the accepted item and rewind the walk
    logic step;      // issue the current cell and advance the walk
    logic read_en;   // start a single-cell read from the store
    logic out_load;  // place the result in the output register
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              bad_radius;
    logic              area_empty;
    logic              read_hit;
    logic              walk_last;
    logic              pipe_busy;
    logic              out_free;
  } status_t;

endpackage

/* src/crf_ram.sv */
module crf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/crf_ctrl.sv */
module crf_ctrl import crf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t stat,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_stall     = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.kind)
          KIND_DRAW: begin
            if (stat.bad_radius || stat.area_empty) begin
              state_nxt = ST_RESULT;
            end else begin
              state_nxt = ST_SETUP;
            end
          end
          KIND_CLEAR: begin
            state_nxt = stat.area_empty ? ST_RESULT : ST_SETUP;
          end
          KIND_READ: begin
            state_nxt = stat.read_hit ? ST_READ : ST_RESULT;
          end
          default: state_nxt = ST_RESULT;
        endcase
      end
      // A wait state for the squared radius terms to settle in their registers.
      ST_SETUP: state_nxt = ST_WALK;
      ST_WALK: begin
        cmd.step = 1'b1;
        if (stat.walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_READ: begin
        cmd.read_en = 1'b1;
        state_nxt   = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* src/crf_datapath.sv */
module crf_datapath import crf_pkg::*; #(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output status_t              stat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [AREA_W-1:0]    cfg_data,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [FIELD_W-1:0]   in_center_x,
  input  logic [FIELD_W-1:0]   in_center_y,
  input  logic [FIELD_W-1:0]   in_radius,
  input  logic                 in_filled,
  input  logic [BYTE_W-1:0]    in_paint_byte,
  input  logic [BYTE_W-1:0]    in_read_col,
  input  logic [BYTE_W-1:0]    in_read_row,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_cell_byte,
  output logic                 out_bad_radius
);

  localparam int CW       = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW     = (CW > AREA_W) ? CW : AREA_W;
  localparam int SIDE_CAP = (MAX_SIDE > AREA_MAX) ? AREA_MAX : MAX_SIDE;
  localparam int POSW     = CW + FRAC_BITS;
  localparam int DW       = ((POSW + 1 > FIELD_W) ? POSW + 1 : FIELD_W) + 1;
  localparam int PW       = 2 * DW;
  localparam int SUMW     = PW + 1;
  localparam int RMW      = FIELD_W + 1;

  // Configuration registers.
  logic [AREA_W-1:0] area_width_r, area_height_r;
  logic [BYTE_W-1:0] background_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_width_r  <= AREA_RESET;
      area_height_r <= AREA_RESET;
      background_r  <= BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AREA_WIDTH:  area_width_r  <= cfg_data;
        CFG_AREA_HEIGHT: area_height_r <= cfg_data;
        CFG_BACKGROUND:  background_r  <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [AREA_W-1:0] w_lim, h_lim;
  assign w_lim = (area_width_r > AREA_W'(SIDE_CAP)) ? AREA_W'(SIDE_CAP) : area_width_r;
  assign h_lim = (area_height_r > AREA_W'(SIDE_CAP)) ? AREA_W'(SIDE_CAP) : area_height_r;

  // Latched item.
  logic [KIND_W-1:0]         kind_r;
  logic signed [FIELD_W-1:0] cx_r, cy_r, rad_r;
  logic                      full_r;
  logic [BYTE_W-1:0]         paint_r, rcol_r, rrow_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      cx_r    <= in_center_x;
      cy_r    <= in_center_y;
      rad_r   <= in_radius;
      full_r  <= in_filled;
      paint_r <= in_paint_byte;
      rcol_r  <= in_read_col;
      rrow_r  <= in_read_row;
    end
  end

  logic is_clear;
  assign is_clear = (kind_r == KIND_CLEAR);

  // Squared radius terms, recomputed every cycle from the held item.
  logic signed [2*FIELD_W-1:0] r2_r;
  logic signed [2*RMW-1:0]     rm2_r;
  logic signed [RMW-1:0]       rm;
  logic                        rm_neg_r;

  assign rm = RMW'(rad_r) - RMW'(1 << FRAC_BITS);

  always_ff @(posedge clk) begin
    r2_r     <= rad_r * rad_r;
    rm2_r    <= rm * rm;
    rm_neg_r <= rm[RMW-1];
  end

  // Walk counters: column, row, linear address and address of the row start.
  logic [CW-1:0] col_r, row_r;
  logic [AW-1:0] addr_r, base_r;
  logic          col_last, row_last;

  assign col_last = (CMPW'(col_r) == CMPW'(w_lim) - CMPW'(1));
  assign row_last = (CMPW'(row_r) == CMPW'(h_lim) - CMPW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      col_r  <= '0;
      row_r  <= '0;
      addr_r <= '0;
      base_r <= '0;
    end else if (cmd.step) begin
      if (col_last) begin
        col_r  <= '0;
        row_r  <= row_r + CW'(1);
        base_r <= base_r + AW'(MAX_SIDE);
        addr_r <= base_r + AW'(MAX_SIDE);
      end else begin
        col_r  <= col_r + CW'(1);
        addr_r <= addr_r + AW'(1);
      end
    end
  end

  // Distance pipeline: offsets, then squares, then the compare at the write.
  logic                 v1_r, v2_r;
  logic [AW-1:0]        a1_r, a2_r;
  logic signed [DW-1:0] dx1_r, dy1_r;
  logic signed [PW-1:0] sqx2_r, sqy2_r;
  logic signed [DW-1:0] dx_nxt, dy_nxt;

  assign dx_nxt = $signed({{(DW-POSW){1'b0}}, col_r, {FRAC_BITS{1'b0}}}) - DW'(cx_r);
  assign dy_nxt = $signed({{(DW-POSW){1'b0}}, row_r, {FRAC_BITS{1'b0}}}) - DW'(cy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.step;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r   <= addr_r;
    dx1_r  <= dx_nxt;
    dy1_r  <= dy_nxt;
    a2_r   <= a1_r;
    sqx2_r <= dx1_r * dx1_r;
    sqy2_r <= dy1_r * dy1_r;
  end

  logic signed [SUMW-1:0] d2;
  logic                   covered;

  assign d2      = SUMW'(sqx2_r) + SUMW'(sqy2_r);
  assign covered = (d2 <= SUMW'(r2_r)) && (full_r || rm_neg_r || (d2 > SUMW'(rm2_r)));

  // Cell store.
  logic              mem_we;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;
  logic [AW-1:0]     mem_raddr;
  logic              read_hit;

  assign mem_we    = v2_r && (is_clear || covered);
  assign mem_wdata = is_clear ? background_r : paint_r;
  assign read_hit  = ({1'b0, rcol_r} < w_lim) && ({1'b0, rrow_r} < h_lim);
  assign mem_raddr = AW'(rrow_r) * AW'(MAX_SIDE) + AW'(rcol_r);

  crf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (a2_r),
    .wdata (mem_wdata),
    .re    (cmd.read_en),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register.
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_cell_r;
  logic              out_bad_r;
  logic              bad_radius;

  assign bad_radius = (kind_r == KIND_DRAW) && (rad_r[FIELD_W-1] || (rad_r == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cell_r <= ((kind_r == KIND_READ) && read_hit) ? mem_rdata : '0;
      out_bad_r  <= bad_radius;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_byte  = out_cell_r;
  assign out_bad_radius = out_bad_r;

  assign stat.kind       = kind_r;
  assign stat.bad_radius = bad_radius;
  assign stat.area_empty = (w_lim == '0) || (h_lim == '0);
  assign stat.read_hit   = read_hit;
  assign stat.walk_last  = col_last && row_last;
  assign stat.pipe_busy  = v1_r || v2_r;
  assign stat.out_free   = !out_valid_r || !out_stall;

endmodule

/* src/circle_raster_framebuffer_top.sv */
// Character framebuffer with a circle painter. A clear item writes the
// background byte into every cell of the area in use, and a draw item visits
// every cell and paints those whose squared distance to the centre lies within
// the disc or, in outline mode, within the band one unit inside the radius.
// Both walk the area one cell per cycle through the walk counters and the single
// write port of the cell store; a draw with a non-positive radius, a read and an
// unused kind do not walk the area. One item is worked on at a time, and each
// gives exactly one result, held in an output register so that the next item
// can be taken while it waits.
// Cells never written since reset read back as undefined.
module circle_raster_framebuffer_top import crf_pkg::*; #(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [AREA_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [FIELD_W-1:0]   in_center_x,
  input  logic [FIELD_W-1:0]   in_center_y,
  input  logic [FIELD_W-1:0]   in_radius,
  input  logic                 in_filled,
  input  logic [BYTE_W-1:0]    in_paint_byte,
  input  logic [BYTE_W-1:0]    in_read_col,
  input  logic [BYTE_W-1:0]    in_read_row,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_cell_byte,
  output logic                 out_bad_radius
);

  cmd_t    cmd;
  status_t stat;

  crf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  crf_datapath #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_kind        (in_kind),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius      (in_radius),
    .in_filled      (in_filled),
    .in_paint_byte  (in_paint_byte),
    .in_read_col    (in_read_col),
    .in_read_row    (in_read_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_byte  (out_cell_byte),
    .out_bad_radius (out_bad_radius)
  );

endmodule
